FILE: hdl/sms_pkg.sv
// Shared types and constants of the supply monitor smoother.
`default_nettype none
package sms_pkg;

   localparam logic [1:0] CH_SUPPLY  = 2'd0;
   localparam logic [1:0] CH_INPUT   = 2'd1;
   localparam logic [1:0] CH_CURRENT = 2'd2;
   localparam logic [1:0] CH_NONE    = 2'd3;

   localparam logic [2:0] CSR_REF_MV    = 3'd0;
   localparam logic [2:0] CSR_DIV_HIGH  = 3'd1;
   localparam logic [2:0] CSR_DIV_LOW   = 3'd2;
   localparam logic [2:0] CSR_SENSE_RES = 3'd3;
   localparam logic [2:0] CSR_AMP_RES   = 3'd4;

   localparam logic [10:0] REF_MV_RESET    = 11'd1100;
   localparam logic [15:0] DIV_HIGH_RESET  = 16'd10000;
   localparam logic [15:0] DIV_LOW_RESET   = 16'd2200;
   localparam logic [15:0] SENSE_RES_RESET = 16'd200;
   localparam logic [15:0] AMP_RES_RESET   = 16'd1000;

   localparam int SUPPLY_SHIFT = 10;    // times 1024
   localparam int DIV_LOW_SHIFT = 8;    // times 256
   localparam logic [6:0] CUR_GAIN = 7'd98;

   localparam int NUM_W = 36;
   localparam int DEN_W = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_DSTART,
      ST_DIV,
      ST_RING,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef enum logic [1:0] {
      R_IDLE,
      R_FILL,
      R_UPDATE,
      R_MEAN
   } ring_state_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic [15:0] value;
      logic        sat;
   } result_type;

   typedef struct packed {
      logic [1:0]  chan;
      logic [15:0] value;
      logic        sat;
      logic        filt;
   } ring_req_type;

endpackage
`default_nettype wire

FILE: hdl/sms_div.sv
// Bit-serial restoring divider with 16-bit saturating quotient.
`default_nettype none
module sms_div import sms_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        div_start,
   input  wire div_req_type div_req,
   output logic             div_done,
   output result_type       div_result
);

   div_state_type     state_ff, state_in;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [15:0]       low_ff;
   logic [15:0]       q_ff;
   logic [3:0]        cnt_ff;
   logic              sat_ff;
   logic [DEN_W:0]    trial;
   logic              trial_ge;
   logic              overflow;

   assign overflow = (div_req.den == '0) ||
                     (DEN_W'(div_req.num[NUM_W-1:16]) >= div_req.den);
   assign trial    = {rem_ff, low_ff[15]};
   assign trial_ge = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      div_done = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (div_start) begin
               state_in = overflow ? DIV_DONE : DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (cnt_ff == '0) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            div_done = 1'b1;
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == DIV_IDLE && div_start) begin
         den_ff <= div_req.den;
         rem_ff <= DEN_W'(div_req.num[NUM_W-1:16]);
         low_ff <= div_req.num[15:0];
         cnt_ff <= 4'hF;
         sat_ff <= overflow;
         q_ff   <= overflow ? 16'hFFFF : 16'h0000;
      end else if (state_ff == DIV_RUN) begin
         rem_ff <= trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         low_ff <= {low_ff[14:0], 1'b0};
         q_ff   <= {q_ff[14:0], trial_ge};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign div_result = '{value: q_ff, sat: sat_ff};

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_RUN && cnt_ff == '0) |=> (state_ff == DIV_DONE))
      else $error("divider did not finish after last bit");
   a_early_is_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DIV_DONE && $past(state_ff) == DIV_IDLE) |-> sat_ff)
      else $error("divider skipped iterations without saturation");
`endif

endmodule
`default_nettype wire

FILE: hdl/sms_ring.sv
// Per-channel averaging rings in one memory, running sums and mean.
`default_nettype none
module sms_ring import sms_pkg::*; #(
   parameter int AVG_DEPTH = 8,
   parameter int AVG_SHIFT = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         ring_start,
   input  wire ring_req_type ring_req,
   output logic              ring_done,
   output result_type        ring_result
);

   localparam int PW        = $clog2(AVG_DEPTH);
   localparam int SUM_W     = 16 + PW;
   localparam int MEM_AW    = PW + 2;
   localparam int MEM_DEPTH = 3 << PW;

   ring_state_type    state_ff, state_in;
   logic [PW-1:0]     pos_ff [3];
   logic [SUM_W-1:0]  sum_ff [3];
   logic [2:0]        primed_ff;
   ring_req_type      req_ff;
   logic [PW-1:0]     npos_ff;
   logic [PW-1:0]     cnt_ff;
   logic [15:0]       mem [MEM_DEPTH];
   logic [15:0]       rd_ff;

   logic [PW-1:0]     cur_pos;
   logic [PW-1:0]     npos_calc;
   logic [MEM_AW-1:0] mem_raddr;
   logic [MEM_AW-1:0] mem_waddr;
   logic              mem_we;
   logic              fill_last;
   logic [SUM_W-1:0]  sum_cur;
   logic [SUM_W-1:0]  shifted;
   logic              mean_big;

   assign cur_pos   = pos_ff[ring_req.chan];
   assign npos_calc = (cur_pos == PW'(AVG_DEPTH - 1)) ? '0 : cur_pos + 1'b1;
   assign mem_raddr = {ring_req.chan, npos_calc};
   assign fill_last = cnt_ff == PW'(AVG_DEPTH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mem_we    = 1'b0;
      mem_waddr = {req_ff.chan, npos_ff};
      ring_done = 1'b0;
      unique case (state_ff)
         R_IDLE: begin
            if (ring_start) begin
               state_in = primed_ff[ring_req.chan] ? R_UPDATE : R_FILL;
            end
         end
         R_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = {req_ff.chan, cnt_ff};
            if (fill_last) begin
               state_in = R_MEAN;
            end
         end
         R_UPDATE: begin
            mem_we   = 1'b1;
            state_in = R_MEAN;
         end
         R_MEAN: begin
            ring_done = 1'b1;
            state_in  = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_ff.value;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == R_IDLE && ring_start) begin
         req_ff  <= ring_req;
         npos_ff <= npos_calc;
         cnt_ff  <= '0;
      end else if (state_ff == R_FILL) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
         primed_ff <= '0;
      end else begin
         if (state_ff == R_IDLE && ring_start) begin
            pos_ff[ring_req.chan] <= npos_calc;
         end
         if (state_ff == R_FILL && fill_last) begin
            sum_ff[req_ff.chan]    <= SUM_W'(req_ff.value) * SUM_W'(AVG_DEPTH);
            primed_ff[req_ff.chan] <= 1'b1;
         end
         if (state_ff == R_UPDATE) begin
            sum_ff[req_ff.chan] <= sum_ff[req_ff.chan] - SUM_W'(rd_ff)
                                   + SUM_W'(req_ff.value);
         end
      end
   end

   assign sum_cur  = sum_ff[req_ff.chan];
   assign shifted  = sum_cur >> AVG_SHIFT;
   assign mean_big = |shifted[SUM_W-1:16];

   always_comb begin
      if (req_ff.filt) begin
         ring_result.value = mean_big ? 16'hFFFF : shifted[15:0];
         ring_result.sat   = req_ff.sat | mean_big;
      end else begin
         ring_result.value = req_ff.value;
         ring_result.sat   = req_ff.sat;
      end
   end

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ring_start |-> (state_ff == R_IDLE))
      else $error("ring started while busy");
   a_update_primed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == R_UPDATE || state_ff == R_MEAN) |-> primed_ff[req_ff.chan])
      else $error("ring updated on channel not primed");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == R_FILL) |-> (cnt_ff <= PW'(AVG_DEPTH - 1)))
      else $error("ring fill ran past depth");
`endif

endmodule
`default_nettype wire

FILE: hdl/supply_monitor_smoother.sv
// Top level: scaling sequencer, configuration registers and result register.
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/req_stall | req_type, req_adc_sample, req_want_filtered
//   rsp      | out       | rsp_valid/rsp_stall | rsp_scaled_value, rsp_saturated
//   csr      | in        | csr_wen             | csr_index, csr_wdata
//
// An item runs from accept to accept through two multiply steps, divider start, the
// serial divide plus a done step, ring update, mean, result and idle.
// A saturating divide skips the serial divide, an unused-channel item goes straight
// to the result step, and a channel's first item after reset fills its ring instead.
// Reset is synchronous and loads the register defaults and empty rings.
// A stalled result holds the output register; the next item waits in the done step.
`default_nettype none
module supply_monitor_smoother import sms_pkg::*; #(
   parameter int AVG_DEPTH = 8,
   parameter int AVG_SHIFT = 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [9:0]  req_adc_sample,
   input  wire logic        req_want_filtered,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_scaled_value,
   output logic             rsp_saturated,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   state_type     state_ff, state_in;
   logic [10:0]   ref_ff;
   logic [15:0]   div_high_ff;
   logic [15:0]   div_low_ff;
   logic [15:0]   sense_ff;
   logic [15:0]   amp_ff;

   logic [1:0]    type_ff;
   logic [9:0]    s_ff;
   logic          filt_ff;
   logic [20:0]   p1_ff;
   logic [31:0]   dprod_ff;
   logic [16:0]   rsum_ff;
   div_req_type   div_req_ff;
   div_req_type   div_req_in;
   result_type    res_ff;
   logic          rsp_valid_ff;
   result_type    rsp_ff;

   logic          div_start;
   logic          div_done;
   result_type    div_result;
   logic          ring_start;
   ring_req_type  ring_req;
   logic          ring_done;
   result_type    ring_result;
   logic          rsp_load;

   sms_div u_div (
      .clock      (clock),
      .reset      (reset),
      .div_start  (div_start),
      .div_req    (div_req_ff),
      .div_done   (div_done),
      .div_result (div_result)
   );

   sms_ring #(
      .AVG_DEPTH (AVG_DEPTH),
      .AVG_SHIFT (AVG_SHIFT)
   ) u_ring (
      .clock       (clock),
      .reset       (reset),
      .ring_start  (ring_start),
      .ring_req    (ring_req),
      .ring_done   (ring_done),
      .ring_result (ring_result)
   );

   assign ring_req = '{chan: type_ff, value: div_result.value,
                       sat: div_result.sat, filt: filt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff      <= REF_MV_RESET;
         div_high_ff <= DIV_HIGH_RESET;
         div_low_ff  <= DIV_LOW_RESET;
         sense_ff    <= SENSE_RES_RESET;
         amp_ff      <= AMP_RES_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_REF_MV:    ref_ff      <= csr_wdata[10:0];
            CSR_DIV_HIGH:  div_high_ff <= csr_wdata;
            CSR_DIV_LOW:   div_low_ff  <= csr_wdata;
            CSR_SENSE_RES: sense_ff    <= csr_wdata;
            CSR_AMP_RES:   amp_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      div_start  = 1'b0;
      ring_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = (req_type == CH_NONE) ? ST_DONE : ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               ring_start = 1'b1;
               state_in   = ST_RING;
            end
         end
         ST_RING: begin
            if (ring_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      unique case (type_ff)
         CH_SUPPLY: begin
            div_req_in.num = NUM_W'(ref_ff) << SUPPLY_SHIFT;
            div_req_in.den = DEN_W'(s_ff);
         end
         CH_INPUT: begin
            div_req_in.num = NUM_W'(p1_ff[20:1]) * NUM_W'(rsum_ff[16:1]);
            div_req_in.den = DEN_W'(div_low_ff) << DIV_LOW_SHIFT;
         end
         CH_CURRENT: begin
            div_req_in.num = NUM_W'(p1_ff) * NUM_W'(CUR_GAIN);
            div_req_in.den = dprod_ff;
         end
         default: begin
            div_req_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         type_ff <= req_type;
         s_ff    <= req_adc_sample;
         filt_ff <= req_want_filtered;
         res_ff  <= '0;
      end
      if (state_ff == ST_MUL1) begin
         p1_ff    <= 21'(ref_ff) * 21'(s_ff);
         dprod_ff <= 32'(amp_ff) * 32'(sense_ff);
         rsum_ff  <= 17'(div_high_ff) + 17'(div_low_ff);
      end
      if (state_ff == ST_MUL2) begin
         div_req_ff <= div_req_in;
      end
      if (state_ff == ST_RING && ring_done) begin
         res_ff <= ring_result;
      end
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scaled_value = rsp_ff.value;
   assign rsp_saturated    = rsp_ff.sat;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while one is in flight");
   a_div_done_place: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside divide step");
   a_ring_done_place: assert property (@(posedge clock) disable iff (reset)
      ring_done |-> (state_ff == ST_RING))
      else $error("ring finished outside ring step");
   a_hold_finished: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("finished item dropped while output stalled");
`endif

endmodule
`default_nettype wire
